// File: design/assert_macros.svh
// assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PS2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold outside reset
`define PS2_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/ps2s1_pkg.sv
// types, byte codes and key table of the set-1 scancode decoder
package ps2s1_pkg;

  typedef enum logic [3:0] {
    ST_NORMAL     = 4'd0,
    ST_E0         = 4'd1,
    ST_E02A       = 4'd2,
    ST_E02AE0     = 4'd3,
    ST_E0B7       = 4'd4,
    ST_E0B7E0     = 4'd5,
    ST_E1         = 4'd6,
    ST_E11D       = 4'd7,
    ST_E11D45     = 4'd8,
    ST_E11D45E1   = 4'd9,
    ST_E11D45E19D = 4'd10,
    ST_INVALID    = 4'd11
  } state_e;

  // prefix and sequence bytes
  localparam logic [7:0] ByteE0 = 8'hE0;
  localparam logic [7:0] ByteE1 = 8'hE1;
  localparam logic [7:0] Byte2A = 8'h2A;
  localparam logic [7:0] ByteB7 = 8'hB7;
  localparam logic [7:0] Byte37 = 8'h37;
  localparam logic [7:0] ByteAA = 8'hAA;
  localparam logic [7:0] Byte1D = 8'h1D;
  localparam logic [7:0] Byte45 = 8'h45;
  localparam logic [7:0] Byte9D = 8'h9D;
  localparam logic [7:0] ByteC5 = 8'hC5;

  // key indices
  localparam logic [7:0] KeyPrtScAlias = 8'hAA;
  localparam logic [7:0] KeyPrtSc      = 8'hB7;
  localparam logic [7:0] KeyCaps       = 8'h3A;
  localparam logic [7:0] KeyNum        = 8'h45;
  localparam logic [7:0] KeyScroll     = 8'h46;
  localparam logic [7:0] KeyLShift     = 8'h2A;
  localparam logic [7:0] KeyRShift     = 8'h36;
  localparam logic [7:0] KeyLCtrl      = 8'h1D;
  localparam logic [7:0] KeyRCtrl      = 8'h9D;
  localparam logic [7:0] KeyAlt        = 8'h38;
  localparam logic [7:0] KeyAltGr      = 8'hB8;
  localparam logic [7:0] KeyLSuper     = 8'hDB;
  localparam logic [7:0] KeyRSuper     = 8'hDC;

  // modifier flag positions
  localparam int ModShift  = 0;
  localparam int ModCaps   = 1;
  localparam int ModNum    = 2;
  localparam int ModScroll = 3;
  localparam int ModAlt    = 4;
  localparam int ModAltGr  = 5;
  localparam int ModCtrl   = 6;
  localparam int ModLSuper = 7;
  localparam int ModRSuper = 8;
  localparam int ModW      = 9;

  // bit n marks key index n as mapped
  localparam logic [255:0] KnownMap = {
    32'h00003FE8, 32'hF80FABA0, 32'h01A54417, 32'h32010000,
    32'h00000000, 32'h018FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE
  };

  typedef struct packed {
    logic       emit;
    logic [7:0] idx;
    logic       known;
    logic       released;
  } dec_t;

  typedef struct packed {
    logic [1:0]      shift_cnt;
    logic [1:0]      ctrl_cnt;
    logic [ModW-1:0] flags;
  } mod_stat_t;

endpackage

// File: design/ps2s1_fsm.sv
// prefix sequence state machine and key index decode
module ps2s1_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_i,
  input  logic              adv_i,
  output ps2s1_pkg::dec_t   dec_o
);

  ps2s1_pkg::state_e state_q, state_d;
  logic              emit;
  logic              prefixed;
  logic [7:0]        idx_raw;
  logic [7:0]        idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2s1_pkg::ST_NORMAL;
    end else if (adv_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = ps2s1_pkg::ST_NORMAL;
    emit     = 1'b0;
    prefixed = 1'b0;
    unique case (state_q)
      ps2s1_pkg::ST_NORMAL: begin
        if (byte_i == ps2s1_pkg::ByteE0) begin
          state_d = ps2s1_pkg::ST_E0;
        end else if (byte_i == ps2s1_pkg::ByteE1) begin
          state_d = ps2s1_pkg::ST_E1;
        end else begin
          emit = 1'b1;
        end
      end
      ps2s1_pkg::ST_E0: begin
        if (byte_i == ps2s1_pkg::Byte2A) begin
          state_d = ps2s1_pkg::ST_E02A;
        end else if (byte_i == ps2s1_pkg::ByteB7) begin
          state_d = ps2s1_pkg::ST_E0B7;
        end else begin
          emit     = 1'b1;
          prefixed = 1'b1;
        end
      end
      ps2s1_pkg::ST_E02A: begin
        state_d = (byte_i == ps2s1_pkg::ByteE0) ? ps2s1_pkg::ST_E02AE0
                                                : ps2s1_pkg::ST_INVALID;
      end
      ps2s1_pkg::ST_E02AE0: begin
        emit     = (byte_i == ps2s1_pkg::Byte37);
        prefixed = 1'b1;
      end
      ps2s1_pkg::ST_E0B7: begin
        state_d = (byte_i == ps2s1_pkg::ByteE0) ? ps2s1_pkg::ST_E0B7E0
                                                : ps2s1_pkg::ST_INVALID;
      end
      ps2s1_pkg::ST_E0B7E0: begin
        emit     = (byte_i == ps2s1_pkg::ByteAA);
        prefixed = 1'b1;
      end
      ps2s1_pkg::ST_E1: begin
        state_d = (byte_i == ps2s1_pkg::Byte1D) ? ps2s1_pkg::ST_E11D
                                                : ps2s1_pkg::ST_INVALID;
      end
      ps2s1_pkg::ST_E11D: begin
        state_d = (byte_i == ps2s1_pkg::Byte45) ? ps2s1_pkg::ST_E11D45
                                                : ps2s1_pkg::ST_INVALID;
      end
      ps2s1_pkg::ST_E11D45: begin
        state_d = (byte_i == ps2s1_pkg::ByteE1) ? ps2s1_pkg::ST_E11D45E1
                                                : ps2s1_pkg::ST_INVALID;
      end
      ps2s1_pkg::ST_E11D45E1: begin
        state_d = (byte_i == ps2s1_pkg::Byte9D) ? ps2s1_pkg::ST_E11D45E19D
                                                : ps2s1_pkg::ST_INVALID;
      end
      ps2s1_pkg::ST_E11D45E19D: begin
        emit     = (byte_i == ps2s1_pkg::ByteC5);
        prefixed = 1'b1;
      end
      default: begin
        // invalid state and unused codes: wait for a sequence end byte
        if (byte_i == ps2s1_pkg::Byte37 || byte_i == ps2s1_pkg::ByteAA ||
            byte_i == ps2s1_pkg::ByteC5) begin
          state_d = ps2s1_pkg::ST_NORMAL;
        end else begin
          state_d = ps2s1_pkg::ST_INVALID;
        end
      end
    endcase
  end

  assign idx_raw = {prefixed, byte_i[6:0]};
  assign idx     = (idx_raw == ps2s1_pkg::KeyPrtScAlias) ? ps2s1_pkg::KeyPrtSc : idx_raw;

  assign dec_o.emit     = emit;
  assign dec_o.idx      = idx;
  assign dec_o.known    = ps2s1_pkg::KnownMap[idx];
  assign dec_o.released = byte_i[7];

endmodule

// File: design/ps2s1_mods.sv
// lock, held and paired modifier tracking
module ps2s1_mods (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ps2s1_pkg::dec_t             dec_i,
  input  logic                        upd_i,
  output logic [ps2s1_pkg::ModW-1:0]  flags_d_o,
  output ps2s1_pkg::mod_stat_t        stat_o
);

  logic [ps2s1_pkg::ModW-1:0] flags_q, flags_d;
  logic [1:0]                 shift_cnt_q, shift_cnt_d;
  logic [1:0]                 ctrl_cnt_q, ctrl_cnt_d;
  logic                       rel;

  assign rel = dec_i.released;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      shift_cnt_q <= '0;
      ctrl_cnt_q  <= '0;
    end else if (upd_i) begin
      flags_q     <= flags_d;
      shift_cnt_q <= shift_cnt_d;
      ctrl_cnt_q  <= ctrl_cnt_d;
    end
  end

  always_comb begin
    flags_d     = flags_q;
    shift_cnt_d = shift_cnt_q;
    ctrl_cnt_d  = ctrl_cnt_q;
    unique case (dec_i.idx) inside
      ps2s1_pkg::KeyCaps: begin
        if (!rel) flags_d[ps2s1_pkg::ModCaps] = ~flags_q[ps2s1_pkg::ModCaps];
      end
      ps2s1_pkg::KeyNum: begin
        if (!rel) flags_d[ps2s1_pkg::ModNum] = ~flags_q[ps2s1_pkg::ModNum];
      end
      ps2s1_pkg::KeyScroll: begin
        if (!rel) flags_d[ps2s1_pkg::ModScroll] = ~flags_q[ps2s1_pkg::ModScroll];
      end
      ps2s1_pkg::KeyLShift, ps2s1_pkg::KeyRShift: begin
        if (!rel) begin
          shift_cnt_d = (shift_cnt_q == 2'd3) ? shift_cnt_q : shift_cnt_q + 2'd1;
          flags_d[ps2s1_pkg::ModShift] = 1'b1;
        end else begin
          shift_cnt_d = (shift_cnt_q == 2'd0) ? shift_cnt_q : shift_cnt_q - 2'd1;
          if (shift_cnt_d == 2'd0) flags_d[ps2s1_pkg::ModShift] = 1'b0;
        end
      end
      ps2s1_pkg::KeyLCtrl, ps2s1_pkg::KeyRCtrl: begin
        if (!rel) begin
          ctrl_cnt_d = (ctrl_cnt_q == 2'd3) ? ctrl_cnt_q : ctrl_cnt_q + 2'd1;
          flags_d[ps2s1_pkg::ModCtrl] = 1'b1;
        end else begin
          ctrl_cnt_d = (ctrl_cnt_q == 2'd0) ? ctrl_cnt_q : ctrl_cnt_q - 2'd1;
          if (ctrl_cnt_d == 2'd0) flags_d[ps2s1_pkg::ModCtrl] = 1'b0;
        end
      end
      ps2s1_pkg::KeyAlt:    flags_d[ps2s1_pkg::ModAlt]    = ~rel;
      ps2s1_pkg::KeyAltGr:  flags_d[ps2s1_pkg::ModAltGr]  = ~rel;
      ps2s1_pkg::KeyLSuper: flags_d[ps2s1_pkg::ModLSuper] = ~rel;
      ps2s1_pkg::KeyRSuper: flags_d[ps2s1_pkg::ModRSuper] = ~rel;
      default: ;
    endcase
  end

  assign flags_d_o        = flags_d;
  assign stat_o.shift_cnt = shift_cnt_q;
  assign stat_o.ctrl_cnt  = ctrl_cnt_q;
  assign stat_o.flags     = flags_q;

endmodule

// File: design/ps2_set1_scancode_decoder.sv
// top level of the ps/2 scancode set 1 decoder
// Takes one raw set-1 keyboard byte per request and gives one result per
// complete key code: the key index (low seven bits, bit 7 set for prefixed
// codes, print screen always reported as 0xB7), whether the index is in the
// mapped key table, a press/release flag and the nine modifier flags after
// the code has been applied. Prefix bytes of the E0, E1, print screen and
// pause sequences, and bytes eaten while resynchronising, give no result.
// A byte is taken into an input register, decoded combinationally against the
// sequence state and modifier registers, and the result lands in an output
// register: one byte per clock cycle sustained while the output register is
// not full and stalled. The loop through the sequence state register sets
// that rate. The output register lets a new byte be decoded while a finished
// result is still waiting, and holds its request for as long as the
// downstream side keeps tready low.
`include "assert_macros.svh"

module ps2_set1_scancode_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: [7:0] scan_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // master side: [7:0] key_index, [8] key_known, [9] key_released,
  // [18:10] modifier_flags, [23:19] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;

  // result register
  logic                       out_vld_q, out_vld_d;
  logic [7:0]                 out_idx_q;
  logic                       out_known_q;
  logic                       out_rel_q;
  logic [ps2s1_pkg::ModW-1:0] out_mods_q;

  ps2s1_pkg::dec_t            dec;
  ps2s1_pkg::mod_stat_t       stat;
  logic [ps2s1_pkg::ModW-1:0] mods_d;
  logic                       out_free;
  logic                       adv;
  logic                       take;

  // the byte in the input register moves on unless it has a result and the
  // result register is full and stalled
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign adv      = in_vld_q && (!dec.emit || out_free);
  assign take     = adv && dec.emit;

  assign s_axis_tready_o = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready_o) in_vld_d = s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q <= s_axis_tdata_i;
  end

  ps2s1_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .adv_i  (adv),
    .dec_o  (dec)
  );

  ps2s1_mods u_mods (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dec_i     (dec),
    .upd_i     (take),
    .flags_d_o (mods_d),
    .stat_o    (stat)
  );

  // result register: load on a new result, drop once downstream takes it
  always_comb begin
    out_vld_d = out_vld_q;
    if (take) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_idx_q   <= dec.idx;
      out_known_q <= dec.known;
      out_rel_q   <= dec.released;
      out_mods_q  <= mods_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_mods_q, out_rel_q, out_known_q, out_idx_q};

  // a new result only ever comes from a decoded byte that completed a code
  `PS2_ASSERT(a_result_source, $rose(out_vld_q) |-> $past(take), "result without a code")

  // a byte waiting in the input register is never overwritten or lost
  `PS2_ASSERT(a_input_held,
              (in_vld_q && !adv) |=> (in_vld_q && $stable(in_byte_q)), "input byte lost")

  // pair flags follow their press counters
  `PS2_ASSERT(a_shift_cnt,
              stat.flags[ps2s1_pkg::ModShift] == (stat.shift_cnt != 2'd0),
              "shift flag and counter disagree")
  `PS2_ASSERT(a_ctrl_cnt,
              stat.flags[ps2s1_pkg::ModCtrl] == (stat.ctrl_cnt != 2'd0),
              "ctrl flag and counter disagree")

endmodule
